[rtl/ubxfb_pkg.sv]
// Shared types and constants for the UBX frame builder.
`timescale 1ns / 1ps
package ubxfb_pkg;

    // Input command kinds, carried on s_tuser
    typedef enum logic {
        CMD_START   = 1'b0,
        CMD_PAYLOAD = 1'b1
    } t_cmd;

    // One queued job for the back end
    typedef struct packed {
        t_cmd        kind;   // start or payload
        logic        last;   // start: zero length; payload: last byte of frame
        logic [7:0]  data0;  // start: class byte; payload: the payload byte
        logic [7:0]  id;     // start: message id
        logic [15:0] len;    // start: payload length
    } t_entry;

    // Byte position inside the back end's current job
    typedef enum logic [2:0] {
        ST_FIRST,
        ST_SYNC2,
        ST_CLASS,
        ST_ID,
        ST_LENLO,
        ST_LENHI,
        ST_CKA,
        ST_CKB
    } t_step;

    // Queue geometry
    localparam int QDepth = 4;
    localparam int QAw    = $clog2(QDepth);
    localparam int QCw    = $clog2(QDepth + 1);

    // Stream payload layout
    localparam int InDataW = 40;

    // Register indexes and reset values
    localparam logic       REG_SYNC_FIRST  = 1'b0;
    localparam logic       REG_SYNC_SECOND = 1'b1;
    localparam logic [7:0] SYNC_FIRST_RST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND_RST = 8'h62;

endpackage

[rtl/ubxfb_front.sv]
// Front end: accepts commands, tracks the open frame and queues jobs.
`timescale 1ns / 1ps
module ubxfb_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  ubxfb_pkg::t_cmd               i_cmd,
    input  logic [ubxfb_pkg::InDataW-1:0] i_data,
    input  logic                          i_full,
    output logic                          o_push,
    output ubxfb_pkg::t_entry             o_entry
);

    logic        r_open;
    logic        n_open;
    logic [15:0] r_remaining;
    logic [15:0] n_remaining;
    logic        w_accept;
    logic [15:0] w_len;
    logic        w_zero_len;
    logic        w_last_byte;

    assign o_ready     = ~i_full;
    assign w_accept    = i_valid & ~i_full;
    assign w_len       = i_data[31:16];
    assign w_zero_len  = (w_len == 16'd0);
    assign w_last_byte = (r_remaining == 16'd1);

    // Classify the transfer: start, payload for an open frame, or drop
    always_comb begin
        n_open      = r_open;
        n_remaining = r_remaining;
        o_push      = 1'b0;
        o_entry     = '0;
        if (w_accept) begin
            if (i_cmd == ubxfb_pkg::CMD_START) begin
                o_push        = 1'b1;
                o_entry.kind  = ubxfb_pkg::CMD_START;
                o_entry.last  = w_zero_len;
                o_entry.data0 = i_data[7:0];
                o_entry.id    = i_data[15:8];
                o_entry.len   = w_len;
                n_open        = ~w_zero_len;
                n_remaining   = w_len;
            end else if (r_open) begin
                o_push        = 1'b1;
                o_entry.kind  = ubxfb_pkg::CMD_PAYLOAD;
                o_entry.last  = w_last_byte;
                o_entry.data0 = i_data[39:32];
                n_remaining   = r_remaining - 16'd1;
                n_open        = ~w_last_byte;
            end
        end
    end

    // Hold frame tracking state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open      <= 1'b0;
            r_remaining <= 16'd0;
        end else begin
            r_open      <= n_open;
            r_remaining <= n_remaining;
        end
    end

endmodule

[rtl/ubxfb_queue.sv]
// Short job queue between the front and back ends.
`timescale 1ns / 1ps
module ubxfb_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ubxfb_pkg::t_entry i_entry,
    output logic              o_full,
    output logic              o_empty,
    output ubxfb_pkg::t_entry o_head,
    input  logic              i_pop
);

    ubxfb_pkg::t_entry              r_slots [ubxfb_pkg::QDepth];
    logic [ubxfb_pkg::QAw-1:0]      r_wptr;
    logic [ubxfb_pkg::QAw-1:0]      r_rptr;
    logic [ubxfb_pkg::QCw-1:0]      r_count;

    assign o_full  = (r_count == ubxfb_pkg::QCw'(ubxfb_pkg::QDepth));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slots[r_rptr];

    // Store pushed jobs
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wptr] <= i_entry;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[rtl/ubxfb_back.sv]
// Back end: walks each job byte by byte, runs the Fletcher sums, drives the output.
`timescale 1ns / 1ps
module ubxfb_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  ubxfb_pkg::t_entry i_head,
    output logic              o_pop,
    input  logic [7:0]        i_sync_first,
    input  logic [7:0]        i_sync_second,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_byte,
    output logic              o_last
);

    ubxfb_pkg::t_step r_step;
    ubxfb_pkg::t_step n_step;
    logic [7:0]       r_sum_a;
    logic [7:0]       r_sum_b;
    logic [7:0]       n_sum_a;
    logic [7:0]       n_sum_b;
    logic             r_valid;
    logic             n_valid;
    logic [7:0]       r_byte;
    logic [7:0]       n_byte;
    logic             r_last;
    logic             n_last;
    logic             w_adv;
    logic             w_add;
    logic             w_clr;
    logic [7:0]       w_emit;
    logic             w_end;
    logic [7:0]       w_add_byte;
    logic [7:0]       w_sa;
    logic [7:0]       w_sb;

    assign w_adv   = ~i_empty & (~r_valid | i_ready);
    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;

    // Pick the byte for this step and the next step
    always_comb begin
        n_step     = r_step;
        w_add      = 1'b0;
        w_clr      = 1'b0;
        w_emit     = 8'h00;
        w_end      = 1'b0;
        w_add_byte = i_head.data0;
        o_pop      = 1'b0;
        case (r_step)
            ubxfb_pkg::ST_FIRST: begin
                if (i_head.kind == ubxfb_pkg::CMD_START) begin
                    w_emit = i_sync_first;
                    w_clr  = 1'b1;
                    n_step = ubxfb_pkg::ST_SYNC2;
                end else begin
                    w_emit = i_head.data0;
                    w_add  = 1'b1;
                    if (i_head.last) begin
                        n_step = ubxfb_pkg::ST_CKA;
                    end else begin
                        o_pop = w_adv;
                    end
                end
            end
            ubxfb_pkg::ST_SYNC2: begin
                w_emit = i_sync_second;
                n_step = ubxfb_pkg::ST_CLASS;
            end
            ubxfb_pkg::ST_CLASS: begin
                w_emit = i_head.data0;
                w_add  = 1'b1;
                n_step = ubxfb_pkg::ST_ID;
            end
            ubxfb_pkg::ST_ID: begin
                w_emit     = i_head.id;
                w_add_byte = i_head.id;
                w_add      = 1'b1;
                n_step     = ubxfb_pkg::ST_LENLO;
            end
            ubxfb_pkg::ST_LENLO: begin
                w_emit     = i_head.len[7:0];
                w_add_byte = i_head.len[7:0];
                w_add      = 1'b1;
                n_step     = ubxfb_pkg::ST_LENHI;
            end
            ubxfb_pkg::ST_LENHI: begin
                w_emit     = i_head.len[15:8];
                w_add_byte = i_head.len[15:8];
                w_add      = 1'b1;
                if (i_head.last) begin
                    n_step = ubxfb_pkg::ST_CKA;
                end else begin
                    n_step = ubxfb_pkg::ST_FIRST;
                    o_pop  = w_adv;
                end
            end
            ubxfb_pkg::ST_CKA: begin
                w_emit = r_sum_a;
                n_step = ubxfb_pkg::ST_CKB;
            end
            ubxfb_pkg::ST_CKB: begin
                w_emit = r_sum_b;
                w_end  = 1'b1;
                n_step = ubxfb_pkg::ST_FIRST;
                o_pop  = w_adv;
            end
            default: begin
                n_step = ubxfb_pkg::ST_FIRST;
            end
        endcase
        if (!w_adv) begin
            n_step = r_step;
        end
    end

    // Fletcher sums: a += byte, then b += a
    assign w_sa = r_sum_a + w_add_byte;
    assign w_sb = r_sum_b + w_sa;

    always_comb begin
        n_sum_a = r_sum_a;
        n_sum_b = r_sum_b;
        if (w_adv && w_clr) begin
            n_sum_a = 8'h00;
            n_sum_b = 8'h00;
        end else if (w_adv && w_add) begin
            n_sum_a = w_sa;
            n_sum_b = w_sb;
        end
    end

    // Load the output register or drain it
    always_comb begin
        n_valid = r_valid;
        n_byte  = r_byte;
        n_last  = r_last;
        if (w_adv) begin
            n_valid = 1'b1;
            n_byte  = w_emit;
            n_last  = w_end;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= ubxfb_pkg::ST_FIRST;
            r_sum_a <= 8'h00;
            r_sum_b <= 8'h00;
            r_valid <= 1'b0;
        end else begin
            r_step  <= n_step;
            r_sum_a <= n_sum_a;
            r_sum_b <= n_sum_b;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_last <= n_last;
    end

endmodule

[rtl/ubx_frame_builder.sv]
// Top level of the UBX frame builder: APB registers, front end, job queue, back end.
//
//  Channel   Dir  Handshake                 Contents
//  s_*       in   s_tvalid / s_tready       s_tuser: command; s_tdata: class, id, length, byte
//  m_*       out  m_tvalid / m_tready       m_tdata: frame byte; m_tlast: frame end
//  APB       in   psel & penable, pready=1  sync_first at 0x0, sync_second at 0x4
//
//  A command transfer is taken every cycle while the four-entry job queue has room.
//  The back end sends one byte per cycle while a job is queued and the output is not
//  stalled: a start gives six bytes, a payload byte one, and two checksum bytes end a frame.
//  Input and output stall on their own; the queue and the output register sit between.
//  Reset (synchronous, active low) empties the queue, closes any frame, loads the sync bytes.
`timescale 1ns / 1ps
module ubx_frame_builder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ubxfb_pkg::InDataW-1:0] s_tdata,  // msg_cls[7:0], msg_id[15:8],
                                                    // pay_len[31:16],
                                                    // payload_byte[39:32]
    input  logic                          s_tuser,  // command[0]
    // frame byte stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,  // out_byte[7:0]
    output logic                          m_tlast,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [7:0]        r_sync_first;
    logic [7:0]        r_sync_second;
    logic              w_wr;
    logic              w_push;
    logic              w_pop;
    logic              w_full;
    logic              w_empty;
    ubxfb_pkg::t_entry w_entry;
    ubxfb_pkg::t_entry w_head;
    ubxfb_pkg::t_cmd   w_cmd;

    // Register port
    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= ubxfb_pkg::SYNC_FIRST_RST;
            r_sync_second <= ubxfb_pkg::SYNC_SECOND_RST;
        end else if (w_wr) begin
            if (paddr[2] == ubxfb_pkg::REG_SYNC_FIRST) begin
                r_sync_first <= pwdata[7:0];
            end else begin
                r_sync_second <= pwdata[7:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == ubxfb_pkg::REG_SYNC_SECOND) begin
            prdata = {24'h000000, r_sync_second};
        end else begin
            prdata = {24'h000000, r_sync_first};
        end
    end

    assign w_cmd = ubxfb_pkg::t_cmd'(s_tuser);

    ubxfb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .o_ready (s_tready),
        .i_cmd   (w_cmd),
        .i_data  (s_tdata),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_entry (w_entry)
    );

    ubxfb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    ubxfb_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (w_empty),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .i_sync_first  (r_sync_first),
        .i_sync_second (r_sync_second),
        .o_valid       (m_tvalid),
        .i_ready       (m_tready),
        .o_byte        (m_tdata),
        .o_last        (m_tlast)
    );

endmodule

[sim/tb_ubx_frame_builder.sv]
// Self-checking testbench for the UBX frame builder: directed and random command streams.
`timescale 1ns / 1ps
module tb_ubx_frame_builder;

    // One byte of a frame as it leaves the block
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_wire_byte;

    localparam int DrainCycles = 24;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;  // msg_cls[7:0], msg_id[15:8], pay_len[31:16],
                                 // payload_byte[39:32]
    logic        s_tuser  = 1'b0;  // command[0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;  // out_byte[7:0]
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // Frame model state and register copies
    logic [7:0]  cfg_sync_first  = ubxfb_pkg::SYNC_FIRST_RST;
    logic [7:0]  cfg_sync_second = ubxfb_pkg::SYNC_SECOND_RST;
    logic [7:0]  fl_sum_a  = '0;
    logic [7:0]  fl_sum_b  = '0;
    logic [15:0] fl_left   = '0;
    logic        fl_open   = 1'b0;
    t_wire_byte  frame_bytes_due[$];
    int          items_taken    = 0;
    int          mismatch_count = 0;

    // Idle shaping for both sides
    int          tx_gap_max  = 0;
    int          burst_left  = 0;
    bit          rx_stall_on = 1'b0;
    int          rx_left     = 0;
    bit          rx_level    = 1'b1;

    ubx_frame_builder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Count a failure, report only the first few
    task automatic note_mismatch(input string what, input logic [8:0] want_v,
                                 input logic [8:0] got_v);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t: %s: expected byte %02h last %b, got byte %02h last %b",
                     $realtime, what, want_v[8:1], want_v[0], got_v[8:1], got_v[0]);
        end
    endtask

    // Queue one frame byte as expected output
    function automatic void push_byte(input logic [7:0] b, input logic last);
        t_wire_byte w;
        w.data = b;
        w.last = last;
        frame_bytes_due.push_back(w);
    endfunction

    // Emit a byte that is covered by the Fletcher sums
    function automatic void fold_byte(input logic [7:0] b);
        push_byte(b, 1'b0);
        fl_sum_a = fl_sum_a + b;
        fl_sum_b = fl_sum_b + fl_sum_a;
    endfunction

    // Close the frame with both checksum bytes
    function automatic void push_trailer();
        push_byte(fl_sum_a, 1'b0);
        push_byte(fl_sum_b, 1'b1);
        fl_open = 1'b0;
    endfunction

    // Work out the frame bytes that one command causes
    function automatic void predict_frame_bytes(input ubxfb_pkg::t_cmd cmd,
                                                input logic [7:0] cls,
                                                input logic [7:0] mid,
                                                input logic [15:0] len,
                                                input logic [7:0] pb);
        if (cmd == ubxfb_pkg::CMD_START) begin
            fl_sum_a = '0;
            fl_sum_b = '0;
            push_byte(cfg_sync_first, 1'b0);
            push_byte(cfg_sync_second, 1'b0);
            fold_byte(cls);
            fold_byte(mid);
            fold_byte(len[7:0]);
            fold_byte(len[15:8]);
            fl_left = len;
            fl_open = 1'b1;
            items_taken++;
            if (len == 16'd0) push_trailer();
        end else if (fl_open) begin
            fold_byte(pb);
            fl_left = fl_left - 16'd1;
            items_taken++;
            if (fl_left == 16'd0) push_trailer();
        end
    endfunction

    // Drive one command transfer, with burst gaps ahead of it, and predict on acceptance
    task automatic send_xfer(input ubxfb_pkg::t_cmd cmd, input logic [7:0] cls,
                             input logic [7:0] mid, input logic [15:0] len,
                             input logic [7:0] pb);
        int gap;
        gap = 0;
        if (tx_gap_max > 0 && burst_left <= 0) begin
            gap = $urandom_range(0, tx_gap_max);
            burst_left = $urandom_range(1, 16);
        end
        if (gap > 0) begin
            @(negedge i_clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {pb, len, mid, cls};
        do @(posedge i_clk); while (!s_tready);
        burst_left--;
        predict_frame_bytes(cmd, cls, mid, len, pb);
    endtask

    task automatic send_start(input logic [7:0] cls, input logic [7:0] mid,
                              input logic [15:0] len);
        send_xfer(ubxfb_pkg::CMD_START, cls, mid, len, 8'($urandom));
    endtask

    task automatic send_payload(input logic [7:0] pb);
        send_xfer(ubxfb_pkg::CMD_PAYLOAD, 8'($urandom), 8'($urandom), 16'($urandom), pb);
    endtask

    // Hold the sender until every expected byte has come out, then let the block settle
    task automatic wait_drain();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (frame_bytes_due.size() != 0) @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);
    endtask

    // One APB transfer: setup cycle, then access cycle until pready
    task automatic apb_xfer(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Read both sync registers and compare with the local copies
    task automatic check_sync_regs();
        logic [31:0] rd;
        apb_xfer(1'b0, {ubxfb_pkg::REG_SYNC_FIRST, 2'b00}, '0, rd);
        if (rd[7:0] !== cfg_sync_first)
            note_mismatch("sync_first readback", {cfg_sync_first, 1'b0}, {rd[7:0], 1'b0});
        apb_xfer(1'b0, {ubxfb_pkg::REG_SYNC_SECOND, 2'b00}, '0, rd);
        if (rd[7:0] !== cfg_sync_second)
            note_mismatch("sync_second readback", {cfg_sync_second, 1'b0}, {rd[7:0], 1'b0});
    endtask

    // Write both sync bytes while idle, then read them back
    task automatic write_sync(input logic [7:0] first, input logic [7:0] second);
        logic [31:0] rd;
        wait_drain();
        apb_xfer(1'b1, {ubxfb_pkg::REG_SYNC_FIRST, 2'b00}, {24'd0, first}, rd);
        apb_xfer(1'b1, {ubxfb_pkg::REG_SYNC_SECOND, 2'b00}, {24'd0, second}, rd);
        cfg_sync_first  = first;
        cfg_sync_second = second;
        check_sync_regs();
    endtask

    // Receiver ready pattern: runs of random length, stalled or not
    always @(negedge i_clk) begin
        if (rx_left <= 0) begin
            rx_level = rx_stall_on ? bit'($urandom_range(0, 1)) : 1'b1;
            rx_left  = rx_level ? $urandom_range(1, 12) : $urandom_range(1, 6);
        end
        rx_left--;
        m_tready <= rx_level;
    end

    // Compare each output transfer with the oldest expected byte
    always @(posedge i_clk) begin : check_frame_bytes
        t_wire_byte want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (frame_bytes_due.size() == 0) begin
                note_mismatch("unexpected byte", 9'h000, {m_tdata, m_tlast});
            end else begin
                want = frame_bytes_due.pop_front();
                if (m_tdata !== want.data || m_tlast !== want.last)
                    note_mismatch("frame byte", {want.data, want.last}, {m_tdata, m_tlast});
            end
        end
    end

    // Payload bytes with no frame open, before any frame and after one has closed
    task automatic test_orphan_payload();
        send_payload(8'hA5);
        send_start(8'h01, 8'h02, 16'd1);
        send_payload(8'h5A);
        send_payload(8'hFF);
    endtask

    // Zero length: header and trailer in one go, class and id at both extremes
    task automatic test_zero_length();
        send_start(8'h00, 8'h00, 16'h0000);
        send_start(8'hFF, 8'hFF, 16'h0000);
    endtask

    // Short complete frame with extreme payload bytes
    task automatic test_short_frame();
        send_start(8'h06, 8'h01, 16'd4);
        send_payload(8'h00);
        send_payload(8'hFF);
        send_payload(8'hA5);
        send_payload(8'h5A);
    endtask

    // A new start drops the open frame, including one of full length
    task automatic test_abandon();
        send_start(8'h0A, 8'h04, 16'hFFFF);
        send_payload(8'h11);
        send_payload(8'h22);
        send_start(8'h0B, 8'h05, 16'h0100);
        send_payload(8'h33);
        send_start(8'h0C, 8'h06, 16'd1);
        send_payload(8'h44);
    endtask

    // Mostly well-formed frames with random content, some dropped frames and noise
    task automatic test_random_frames(input int n_items);
        int          stop_at;
        int          r;
        int          n_bytes;
        logic [15:0] len;
        stop_at = items_taken + n_items;
        while (items_taken < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                len = 16'd0;
                n_bytes = 0;
            end else if (r < 78) begin
                len = 16'($urandom_range(1, 6));
                n_bytes = int'(len);
            end else if (r < 88) begin
                len = 16'($urandom_range(7, 40));
                n_bytes = int'(len);
            end else if (r < 94) begin
                len = 16'($urandom_range(5, 65535));
                n_bytes = $urandom_range(0, 4);
            end else begin
                len = '0;
                n_bytes = -1;
            end
            if (n_bytes < 0) begin
                send_payload(8'($urandom));
            end else begin
                send_start(8'($urandom), 8'($urandom), len);
                repeat (n_bytes) send_payload(8'($urandom));
            end
            if ($urandom_range(0, 49) == 0) wait_drain();
        end
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        check_sync_regs();
        test_orphan_payload();
        test_zero_length();
        test_short_frame();
        test_abandon();

        // Steady streams on both sides, sync bytes at opposite extremes
        write_sync(8'h00, 8'hFF);
        tx_gap_max  = 0;
        rx_stall_on = 1'b0;
        test_random_frames(150);

        // Gaps and stalls, sync bytes swapped
        write_sync(8'hFF, 8'h00);
        tx_gap_max  = 5;
        rx_stall_on = 1'b1;
        test_random_frames(150);

        // Random sync bytes, short input gaps and output stalls
        write_sync(8'($urandom), 8'($urandom));
        tx_gap_max  = 2;
        rx_stall_on = 1'b1;
        test_random_frames(145);

        wait_drain();
        if (mismatch_count == 0) begin
            $display("tb_ubx_frame_builder: clean");
        end else begin
            $display("tb_ubx_frame_builder: errors");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #2_000_000;
        $display("tb_ubx_frame_builder: errors");
        $finish;
    end

endmodule

[files.f]
rtl/ubxfb_pkg.sv
rtl/ubxfb_front.sv
rtl/ubxfb_queue.sv
rtl/ubxfb_back.sv
rtl/ubx_frame_builder.sv
sim/tb_ubx_frame_builder.sv
